### rtl/cpcr_pkg.sv
// shared widths, types and helpers for the circle pair collision pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cpcr_pkg;

    localparam int POS_W   = 24;   // center coordinate
    localparam int RAD_W   = 16;   // radius
    localparam int COEF_W  = 9;    // response coefficient, q1.8
    localparam int S_W     = 17;   // radius sum
    localparam int ROOT_W  = 17;   // integer sqrt of the squared distance
    localparam int D2_W    = 34;   // squared distance, only meaningful on a hit
    localparam int TR_W    = D2_W + 2;
    localparam int RC_W    = RAD_W + COEF_W;          // radius times coefficient
    localparam int F_W     = RC_W + S_W;              // times overlap
    localparam int PROD_W  = F_W + ROOT_W;            // times axis distance
    localparam int DEN0_W  = ROOT_W + S_W;            // dist times radius sum
    localparam int DEN_W   = DEN0_W + COEF_W;         // times 512
    localparam int NUM_W   = PROD_W + 2;              // numerator plus half divisor
    localparam int Q_W     = 18;                      // shift magnitude
    localparam int LANES   = 4;
    localparam int DIF_W   = POS_W + 1;
    localparam int SUM_W   = POS_W + 2;

    localparam logic [COEF_W-1:0] COEF_RESET = 9'd192;
    localparam logic signed [SUM_W-1:0] POS_MAX = 26'sd8388607;
    localparam logic signed [SUM_W-1:0] POS_MIN = -26'sd8388608;

    // lane order inside the divider
    localparam int LANE_AX = 0;
    localparam int LANE_AY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;

    typedef struct packed {
        logic                    move;
        logic                    hit;
        logic                    sx;
        logic                    sy;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
    } t_ctx;

    typedef struct packed {
        t_ctx              ctx;
        logic [S_W-1:0]    s;
        logic [RC_W-1:0]   rbc;
        logic [RC_W-1:0]   rac;
        logic [ROOT_W-1:0] mx;
        logic [ROOT_W-1:0] my;
    } t_side;

    typedef logic [LANES-1:0][NUM_W-1:0] t_num_vec;
    typedef logic [LANES-1:0][Q_W-1:0]   t_q_vec;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v > POS_MAX) begin
            res = POS_MAX[POS_W-1:0];
        end else if (v < POS_MIN) begin
            res = POS_MIN[POS_W-1:0];
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/cpcr_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cpcr_pkg; carries the side data of each item along
`timescale 1ns / 1ps

module cpcr_isqrt import cpcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [D2_W-1:0]   i_op,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [TR_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_side             r_side [ROOT_W];
    logic              r_vld  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_st
        localparam int B = ROOT_W - 1 - j;
        logic [TR_W-1:0]   rem_i;
        logic [TR_W-1:0]   trial;
        logic [ROOT_W-1:0] root_i;
        t_side             side_i;
        logic              vld_i;

        if (j == 0) begin : g_first
            assign rem_i  = TR_W'(i_op);
            assign root_i = '0;
            assign side_i = i_side;
            assign vld_i  = i_vld;
        end else begin : g_next
            assign rem_i  = r_rem[j-1];
            assign root_i = r_root[j-1];
            assign side_i = r_side[j-1];
            assign vld_i  = r_vld[j-1];
        end

        // (root + 2^b)^2 - root^2
        assign trial = (TR_W'(root_i) << (B + 1)) + (TR_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (rem_i >= trial) begin
                r_rem[j]  <= rem_i - trial;
                r_root[j] <= root_i | (ROOT_W'(1) << B);
            end else begin
                r_rem[j]  <= rem_i;
                r_root[j] <= root_i;
            end
            r_side[j] <= side_i;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= vld_i;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

### rtl/cpcr_div.sv
// pipelined restoring divider, four lanes sharing one divisor
// depends on cpcr_pkg; one quotient bit per stage
`timescale 1ns / 1ps

module cpcr_div import cpcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_num_vec         i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_ctx             i_ctx,
    output logic             o_vld,
    output t_q_vec           o_q,
    output t_ctx             o_ctx
);

    t_num_vec         r_rem [Q_W];
    t_q_vec           r_q   [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    t_ctx             r_ctx [Q_W];
    logic             r_vld [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_st
        localparam int B = Q_W - 1 - k;
        t_num_vec         rem_i;
        t_q_vec           q_i;
        logic [DEN_W-1:0] den_i;
        t_ctx             ctx_i;
        logic             vld_i;
        logic [NUM_W-1:0] dsh;

        if (k == 0) begin : g_first
            assign rem_i = i_num;
            assign q_i   = '0;
            assign den_i = i_den;
            assign ctx_i = i_ctx;
            assign vld_i = i_vld;
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign q_i   = r_q[k-1];
            assign den_i = r_den[k-1];
            assign ctx_i = r_ctx[k-1];
            assign vld_i = r_vld[k-1];
        end

        assign dsh = NUM_W'(den_i) << B;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (rem_i[l] >= dsh) begin
                    r_rem[k][l] <= rem_i[l] - dsh;
                    r_q[k][l]   <= q_i[l] | (Q_W'(1) << B);
                end else begin
                    r_rem[k][l] <= rem_i[l];
                    r_q[k][l]   <= q_i[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[k] <= den_i;
            r_ctx[k] <= ctx_i;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_i;
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_q   = r_q[Q_W-1];
    assign o_ctx = r_ctx[Q_W-1];

endmodule

### rtl/circle_pair_collision_resolve.sv
// top level of the circle pair collision resolver
// depends on cpcr_pkg, cpcr_isqrt and cpcr_div
`timescale 1ns / 1ps
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------------
//  pair in   | in        | start, busy               | i_a_x i_a_y i_a_radius i_b_x i_b_y
//            |           |                           | i_b_radius
//  result    | out       | o_valid (strobe, no stall)| o_new_a_x o_new_a_y o_new_b_x
//            |           |                           | o_new_b_y o_hit
//  config    | in        | i_cfg_we                  | i_cfg_data (response coefficient)
//
//  one pair per clock outside reset; every transfer gives one result
//  each result passes through the 17-stage square root and the 18-stage divider,
//  plus eight stages of capture, compare, multiply and output logic
//  busy is high only during reset; after reset the pipeline always advances
//  synchronous active-low reset clears the valid chain and loads coefficient 0.75

module circle_pair_collision_resolve import cpcr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] i_a_x,
    input  logic signed [POS_W-1:0] i_a_y,
    input  logic [RAD_W-1:0]        i_a_radius,
    input  logic signed [POS_W-1:0] i_b_x,
    input  logic signed [POS_W-1:0] i_b_y,
    input  logic [RAD_W-1:0]        i_b_radius,
    input  logic                    i_cfg_we,
    input  logic [COEF_W-1:0]       i_cfg_data,
    output logic                    o_valid,
    output logic signed [POS_W-1:0] o_new_a_x,
    output logic signed [POS_W-1:0] o_new_a_y,
    output logic signed [POS_W-1:0] o_new_b_x,
    output logic signed [POS_W-1:0] o_new_b_y,
    output logic                    o_hit
);

    // configuration register
    logic [COEF_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_we) begin
            r_coef <= i_cfg_data;
        end
    end

    assign busy = !i_rst_n;

    // stage 0: input capture
    logic                    r_v0;
    logic signed [POS_W-1:0] r_ax0, r_ay0, r_bx0, r_by0;
    logic [RAD_W-1:0]        r_ra0, r_rb0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_ax0 <= i_a_x;
        r_ay0 <= i_a_y;
        r_bx0 <= i_b_x;
        r_by0 <= i_b_y;
        r_ra0 <= i_a_radius;
        r_rb0 <= i_b_radius;
    end

    // stage 1: center difference, magnitudes, radius sum, radius times coefficient
    logic signed [DIF_W-1:0] vx, vy;
    logic [DIF_W-1:0]        ux, uy;
    logic                    r_v1, r_big1;
    t_side                   r_side1;
    t_side                   n_side1;

    assign vx = DIF_W'(r_ax0) - DIF_W'(r_bx0);
    assign vy = DIF_W'(r_ay0) - DIF_W'(r_by0);
    assign ux = vx[DIF_W-1] ? DIF_W'(-vx) : DIF_W'(vx);
    assign uy = vy[DIF_W-1] ? DIF_W'(-vy) : DIF_W'(vy);

    always_comb begin
        n_side1          = '0;
        n_side1.ctx.sx   = vx[DIF_W-1];
        n_side1.ctx.sy   = vy[DIF_W-1];
        n_side1.ctx.ax   = r_ax0;
        n_side1.ctx.ay   = r_ay0;
        n_side1.ctx.bx   = r_bx0;
        n_side1.ctx.by   = r_by0;
        n_side1.s        = S_W'(r_ra0) + S_W'(r_rb0);
        n_side1.rbc      = RC_W'(r_rb0) * RC_W'(r_coef);
        n_side1.rac      = RC_W'(r_ra0) * RC_W'(r_coef);
        n_side1.mx       = ux[ROOT_W-1:0];
        n_side1.my       = uy[ROOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        // an axis gap of 2^17 or more can never be below the radius sum
        r_big1  <= (ux[DIF_W-1:ROOT_W] != '0) || (uy[DIF_W-1:ROOT_W] != '0);
        r_side1 <= n_side1;
    end

    // stage 2: squares
    logic              r_v2, r_big2;
    logic [D2_W-1:0]   r_sqx2, r_sqy2, r_ss2;
    t_side             r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_big2  <= r_big1;
        r_sqx2  <= D2_W'(r_side1.mx) * D2_W'(r_side1.mx);
        r_sqy2  <= D2_W'(r_side1.my) * D2_W'(r_side1.my);
        r_ss2   <= D2_W'(r_side1.s) * D2_W'(r_side1.s);
        r_side2 <= r_side1;
    end

    // stage 3: overlap test
    logic [D2_W:0]   d2;
    logic            hit3;
    logic            r_v3;
    logic [D2_W-1:0] r_d2_3;
    t_side           r_side3;
    t_side           n_side3;

    assign d2   = {1'b0, r_sqx2} + {1'b0, r_sqy2};
    assign hit3 = !r_big2 && (d2 < {1'b0, r_ss2});

    always_comb begin
        n_side3          = r_side2;
        n_side3.ctx.hit  = hit3;
        // coincident centers: hit but zero normal, nothing moves
        n_side3.ctx.move = hit3 && (d2 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_d2_3  <= d2[D2_W-1:0];
        r_side3 <= n_side3;
    end

    // square root of the squared distance
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    cpcr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v3),
        .i_op    (r_d2_3),
        .i_side  (r_side3),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 4: overlap depth, divisor base, weighted push factors
    logic               r_v4;
    logic [S_W-1:0]     r_ov4;
    logic [ROOT_W-1:0]  r_root4;
    logic [DEN0_W-1:0]  r_den0_4;
    logic [F_W-1:0]     r_fa4, r_fb4;
    t_side              r_side4;
    logic [S_W-1:0]     ov;

    assign ov = sq_side.s - S_W'(sq_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= sq_vld;
        end
        r_ov4    <= ov;
        r_root4  <= sq_root;
        r_den0_4 <= DEN0_W'(sq_root) * DEN0_W'(sq_side.s);
        r_fa4    <= F_W'(sq_side.rbc) * F_W'(ov);
        r_fb4    <= F_W'(sq_side.rac) * F_W'(ov);
        r_side4  <= sq_side;
    end

    // stage 5: times the axis distance
    logic              r_v5;
    logic [PROD_W-1:0] r_p5 [LANES];
    logic [DEN0_W-1:0] r_den0_5;
    t_ctx              r_ctx5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_p5[LANE_AX] <= PROD_W'(r_fa4) * PROD_W'(r_side4.mx);
        r_p5[LANE_AY] <= PROD_W'(r_fa4) * PROD_W'(r_side4.my);
        r_p5[LANE_BX] <= PROD_W'(r_fb4) * PROD_W'(r_side4.mx);
        r_p5[LANE_BY] <= PROD_W'(r_fb4) * PROD_W'(r_side4.my);
        r_den0_5      <= r_den0_4;
        r_ctx5        <= r_side4.ctx;
    end

    // stage 6: add half the divisor for round to nearest
    logic             r_v6;
    t_num_vec         r_num6;
    logic [DEN_W-1:0] r_den6;
    t_ctx             r_ctx6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        for (int l = 0; l < LANES; l++) begin
            r_num6[l] <= NUM_W'(r_p5[l]) + (NUM_W'(r_den0_5) << (COEF_W - 1));
        end
        r_den6 <= {r_den0_5, {COEF_W{1'b0}}};
        r_ctx6 <= r_ctx5;
    end

    logic   dv_vld;
    t_q_vec dv_q;
    t_ctx   dv_ctx;

    cpcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v6),
        .i_num   (r_num6),
        .i_den   (r_den6),
        .i_ctx   (r_ctx6),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_ctx   (dv_ctx)
    );

    // stage 7: apply signed shifts, saturate, register result
    logic signed [SUM_W-1:0] sum_ax, sum_ay, sum_bx, sum_by;

    function automatic logic signed [SUM_W-1:0] apply(
        input logic signed [POS_W-1:0] c,
        input logic [Q_W-1:0]          q,
        input logic                    neg,
        input logic                    en
    );
        logic signed [SUM_W-1:0] d;
        d = SUM_W'(signed'({1'b0, q}));
        if (!en) begin
            d = '0;
        end else if (neg) begin
            d = -d;
        end
        return SUM_W'(c) + d;
    endfunction

    // a moves along +v, b along -v
    assign sum_ax = apply(dv_ctx.ax, dv_q[LANE_AX], dv_ctx.sx, dv_ctx.move);
    assign sum_ay = apply(dv_ctx.ay, dv_q[LANE_AY], dv_ctx.sy, dv_ctx.move);
    assign sum_bx = apply(dv_ctx.bx, dv_q[LANE_BX], !dv_ctx.sx, dv_ctx.move);
    assign sum_by = apply(dv_ctx.by, dv_q[LANE_BY], !dv_ctx.sy, dv_ctx.move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_vld;
        end
        o_new_a_x <= sat_pos(sum_ax);
        o_new_a_y <= sat_pos(sum_ay);
        o_new_b_x <= sat_pos(sum_bx);
        o_new_b_y <= sat_pos(sum_by);
        o_hit     <= dv_ctx.hit;
    end

    // a moving pair has nonzero distance and positive overlap
    a_move_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_side4.ctx.move |-> r_root4 != '0)
        else $error("moving pair with zero root");

    a_move_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_side4.ctx.move |-> r_ov4 != '0)
        else $error("moving pair with no overlap");

    a_move_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld && dv_ctx.move |-> dv_ctx.hit)
        else $error("move without hit");

    a_out_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_v6, Q_W + 1))
        else $error("result strobe without matching divider entry");

endmodule

### tb/testbench.sv
// testbench for circle_pair_collision_resolve: directed and random circle pairs
// depends on cpcr_pkg and the block's rtl; predicts each result in integer math
`timescale 1ns / 1ps

module testbench;
    import cpcr_pkg::*;

    localparam int LATENCY = 43;

    // one expected result
    typedef struct {
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic                    hit;
    } t_resolved;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [POS_W-1:0] i_a_x = '0;
    logic signed [POS_W-1:0] i_a_y = '0;
    logic [RAD_W-1:0]        i_a_radius = '0;
    logic signed [POS_W-1:0] i_b_x = '0;
    logic signed [POS_W-1:0] i_b_y = '0;
    logic [RAD_W-1:0]        i_b_radius = '0;
    logic                    i_cfg_we = 1'b0;
    logic [COEF_W-1:0]       i_cfg_data = '0;
    logic                    o_valid;
    logic signed [POS_W-1:0] o_new_a_x;
    logic signed [POS_W-1:0] o_new_a_y;
    logic signed [POS_W-1:0] o_new_b_x;
    logic signed [POS_W-1:0] o_new_b_y;
    logic                    o_hit;

    t_resolved   pending_results[$];
    logic [8:0]  coef_model;
    int          fail_count = 0;
    int          pairs_sent = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    int          send_gap_pct = 0;

    circle_pair_collision_resolve dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_radius(i_a_radius),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_radius(i_b_radius),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_new_a_x(o_new_a_x), .o_new_a_y(o_new_a_y),
        .o_new_b_x(o_new_b_x), .o_new_b_y(o_new_b_y), .o_hit(o_hit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // vc*factor/den rounded to nearest, ties away from zero
    function automatic longint round_shift(input longint vc, input longint unsigned factor,
                                           input longint unsigned den);
        longint unsigned mag = (vc < 0) ? -vc : vc;
        longint unsigned q = (mag * factor + den / 2) / den;
        return (vc < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[POS_W-1:0];
    endfunction

    function automatic t_resolved resolve_pair(
        input logic signed [POS_W-1:0] ax_in, input logic signed [POS_W-1:0] ay_in,
        input logic [RAD_W-1:0] ra_in, input logic signed [POS_W-1:0] bx_in,
        input logic signed [POS_W-1:0] by_in, input logic [RAD_W-1:0] rb_in);
        t_resolved r;
        longint ax = ax_in, ay = ay_in, bx = bx_in, by = by_in;
        longint unsigned ra = ra_in, rb = rb_in;
        longint vx = ax - bx, vy = ay - by;
        longint unsigned uvx = (vx < 0) ? -vx : vx;
        longint unsigned uvy = (vy < 0) ? -vy : vy;
        longint unsigned d2 = uvx * uvx + uvy * uvy;
        longint unsigned s = ra + rb;
        longint unsigned root_len, ov, den, fa, fb;
        r.hit = 1'b0;
        if (d2 < s * s) begin
            r.hit = 1'b1;
            if (d2 != 0) begin
                root_len = int_sqrt(d2);
                ov = s - root_len;
                den = 512 * root_len * s;
                fa = rb * ov * coef_model;
                fb = ra * ov * coef_model;
                ax += round_shift(vx, fa, den);
                ay += round_shift(vy, fa, den);
                bx -= round_shift(vx, fb, den);
                by -= round_shift(vy, fb, den);
            end
        end
        r.ax = clamp_pos(ax);
        r.ay = clamp_pos(ay);
        r.bx = clamp_pos(bx);
        r.by = clamp_pos(by);
        return r;
    endfunction

    // result checker: every strobe is compared with the oldest prediction
    always @(posedge i_clk) begin
        t_resolved want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no transfer outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit) hits_seen++;
                if (o_new_a_x !== want.ax) begin
                    $error("new_a_x expected %0d actual %0d", want.ax, o_new_a_x);
                    fail_count++;
                end
                if (o_new_a_y !== want.ay) begin
                    $error("new_a_y expected %0d actual %0d", want.ay, o_new_a_y);
                    fail_count++;
                end
                if (o_new_b_x !== want.bx) begin
                    $error("new_b_x expected %0d actual %0d", want.bx, o_new_b_x);
                    fail_count++;
                end
                if (o_new_b_y !== want.by) begin
                    $error("new_b_y expected %0d actual %0d", want.by, o_new_b_y);
                    fail_count++;
                end
                if (o_hit !== want.hit) begin
                    $error("hit expected %0d actual %0d", want.hit, o_hit);
                    fail_count++;
                end
            end
        end
    end

    // one pair transfer; start stays high across back-to-back transfers
    task automatic send_pair(input logic signed [POS_W-1:0] ax, input logic signed [POS_W-1:0] ay,
                             input logic [RAD_W-1:0] ra, input logic signed [POS_W-1:0] bx,
                             input logic signed [POS_W-1:0] by, input logic [RAD_W-1:0] rb);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_a_x <= ax; i_a_y <= ay; i_a_radius <= ra;
        i_b_x <= bx; i_b_y <= by; i_b_radius <= rb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(), resolve_pair(ax, ay, ra, bx, by, rb));
        pairs_sent++;
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // coefficient writes only with the pipeline empty
    task automatic write_coef(input logic [8:0] value);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        coef_model = value;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 256, 100, 0, 256);                  // overlap along x
        send_pair(0, 0, 256, 0, 0, 256);                    // coincident centers
        send_pair(0, 0, 256, 512, 0, 256);                  // exactly touching, no hit
        send_pair(0, 0, 0, 0, 0, 0);                        // both radii zero
        send_pair(0, 0, 0, 10, 10, 300);                    // one zero radius
        send_pair(0, 0, 16'hFFFF, 5, -7, 16'hFFFF);         // max radii
        send_pair(0, 0, 16'hFFFF, 65535, 65535, 16'hFFFF);  // max radii, centers far apart but still overlapping
        send_pair(24'sh7FFFFF, 24'sh7FFFFF, 1000, 24'sh7FFF00, 24'sh7FFF00, 1000);
        send_pair(-24'sh800000, -24'sh800000, 1000, -24'sh7FFF00, -24'sh7FFF00, 1000);
        send_pair(24'sh7FFFFF, 0, 1, -24'sh800000, 0, 1);   // opposite extremes
        send_pair(-24'sh800000, 24'sh7FFFFF, 1, 24'sh7FFFFF, -24'sh800000, 1);
        send_pair(3, -3, 1, 2, -2, 1);                      // tiny circles
        send_pair(-1, -1, 16'hFFFF, 0, 0, 1);               // very unequal masses
        send_pair(24'sh555555, -24'sh2AAAAB, 16'hAAAA, 24'sh555000, -24'sh2AA000, 16'h5555);
    endtask

    task automatic random_pair();
        logic signed [POS_W-1:0] ax, ay, bx, by;
        logic [RAD_W-1:0] ra, rb;
        int span;
        int mode = int'($urandom_range(9));
        ax = POS_W'($urandom);
        ay = POS_W'($urandom);
        if (mode < 2) begin
            // arbitrary pairs, mostly misses
            bx = POS_W'($urandom);
            by = POS_W'($urandom);
            ra = RAD_W'($urandom);
            rb = RAD_W'($urandom);
        end else begin
            // near pairs with random scale so most of them hit
            ra = (mode < 5) ? RAD_W'($urandom_range(1, 2000)) : RAD_W'($urandom_range(1, 65535));
            rb = (mode < 5) ? RAD_W'($urandom_range(1, 2000)) : RAD_W'($urandom_range(1, 65535));
            span = int'(ra) + int'(rb);
            bx = POS_W'(int'(ax) + int'($urandom_range(0, 2 * span)) - span);
            by = POS_W'(int'(ay) + int'($urandom_range(0, 2 * span)) - span);
            if (mode == 9) begin
                bx = ax; by = ay;   // coincident centers
            end
        end
        send_pair(ax, ay, ra, bx, by, rb);
    endtask

    task automatic test_random(input int count, input int gap_pct);
        send_gap_pct = gap_pct;
        repeat (count) random_pair();
        send_gap_pct = 0;
    endtask

    initial begin
        coef_model = COEF_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        test_directed();
        write_coef(9'd0);
        test_directed();
        write_coef(9'd256);
        test_directed();
        write_coef(9'h1FF);
        test_directed();
        write_coef(9'd1);
        test_random(100, 8);

        write_coef(9'd192);
        test_random(500, 8);
        drain_pipeline();                       // pause until all results are back
        write_coef(9'd256);
        test_random(500, 74);
        write_coef(9'($urandom_range(0, 511)));
        test_random(550, 0);

        drain_pipeline();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d circle pairs, checked %0d results (%0d hits)",
                 pairs_sent, results_seen, hits_seen);
        $display("edge cases and random pairs across several coefficient settings");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/cpcr_pkg.sv
rtl/cpcr_isqrt.sv
rtl/cpcr_div.sv
rtl/circle_pair_collision_resolve.sv
tb/testbench.sv
